// ===== hdl/ccs_pkg.sv =====
// package for the color code stripper
// transaction types, pending levels and character class helpers
// no dependencies
`timescale 1ns / 1ps

package ccs_pkg;

  localparam int unsigned MaxRun = 4;
  localparam int unsigned CntW   = 3;
  localparam int unsigned IdxW   = 2;

  localparam logic [7:0] CharCaret = 8'h5E;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  // how much of an escape is held back
  localparam logic [1:0] LvlNone  = 2'd0;
  localparam logic [1:0] LvlCaret = 2'd1;
  localparam logic [1:0] LvlOne   = 2'd2;
  localparam logic [1:0] LvlTwo   = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_end;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_end;
    logic       run_last;
  } out_t;

  // all results caused by one input transaction
  typedef struct packed {
    logic [MaxRun-1:0][7:0] data;
    logic [CntW-1:0]        count;
    logic                   bare;
    logic                   str_end;
  } run_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CharZero) && (c <= CharNine);
  endfunction

  function automatic logic is_color_letter(input logic [7:0] c);
    return (c == 8'h77) || (c == 8'h72) || (c == 8'h79) || (c == 8'h67) ||
           (c == 8'h6B) || (c == 8'h63) || (c == 8'h62) || (c == 8'h6D);
  endfunction

endpackage

// ===== hdl/color_code_stripper.sv =====
// an input transaction passes through the input register and then the result buffer
// throughput: one input per cycle for runs of one result while the output is ready;
// a longer run holds the result buffer until its last result leaves, and a byte
// with no result skips the buffer; the buffer holds a single run and sets the rate
// reset: asynchronous, active low; empties both registers, nothing pending
// top level of the color code stripper; depends on ccs_pkg, ccs_scan, ccs_emit
`timescale 1ns / 1ps

module color_code_stripper (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ccs_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ccs_pkg::out_t out_data_o
);

  logic          in_valid_q;
  ccs_pkg::in_t  in_q;
  logic          free;
  logic          advance;
  ccs_pkg::run_t run;

  assign advance    = in_valid_q && free;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  ccs_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (in_q),
    .run_o     (run)
  );

  // bytes held inside an escape give an empty run and skip the buffer
  ccs_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && (run.count != '0)),
    .run_i       (run),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== hdl/ccs_scan.sv =====
// escape scanner: pending escape state and the result run of one byte
// depends on ccs_pkg
`timescale 1ns / 1ps

module ccs_scan (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          advance_i,
  input  ccs_pkg::in_t  item_i,
  output ccs_pkg::run_t run_o
);

  logic [1:0] lvl_q, lvl_d;
  logic [7:0] d0_q, d0_d, d1_q, d1_d;

  always_comb begin
    logic [7:0]              c;
    logic [ccs_pkg::CntW-1:0] n;
    c       = item_i.in_byte;
    n       = '0;
    lvl_d   = lvl_q;
    d0_d    = d0_q;
    d1_d    = d1_q;
    run_o   = '0;

    if (lvl_q == ccs_pkg::LvlCaret && ccs_pkg::is_color_letter(c)) begin
      lvl_d = ccs_pkg::LvlNone;
    end else if (lvl_q == ccs_pkg::LvlCaret && ccs_pkg::is_digit(c)) begin
      d0_d  = c;
      lvl_d = ccs_pkg::LvlOne;
    end else if (lvl_q == ccs_pkg::LvlOne && ccs_pkg::is_digit(c)) begin
      d1_d  = c;
      lvl_d = ccs_pkg::LvlTwo;
    end else if (lvl_q == ccs_pkg::LvlTwo && ccs_pkg::is_digit(c)) begin
      lvl_d = ccs_pkg::LvlNone;
    end else begin
      // broken escape or plain byte: held bytes go out as plain text
      if (lvl_q != ccs_pkg::LvlNone) begin
        run_o.data[n[ccs_pkg::IdxW-1:0]] = ccs_pkg::CharCaret;
        n = n + 1'b1;
      end
      if (lvl_q == ccs_pkg::LvlOne || lvl_q == ccs_pkg::LvlTwo) begin
        run_o.data[n[ccs_pkg::IdxW-1:0]] = d0_q;
        n = n + 1'b1;
      end
      if (lvl_q == ccs_pkg::LvlTwo) begin
        run_o.data[n[ccs_pkg::IdxW-1:0]] = d1_q;
        n = n + 1'b1;
      end
      if (c == ccs_pkg::CharCaret) begin
        lvl_d = ccs_pkg::LvlCaret;
      end else begin
        lvl_d = ccs_pkg::LvlNone;
        run_o.data[n[ccs_pkg::IdxW-1:0]] = c;
        n = n + 1'b1;
      end
    end

    if (item_i.is_end) begin
      // end of string flushes what is still held
      if (lvl_d != ccs_pkg::LvlNone) begin
        run_o.data[n[ccs_pkg::IdxW-1:0]] = ccs_pkg::CharCaret;
        n = n + 1'b1;
      end
      if (lvl_d == ccs_pkg::LvlOne || lvl_d == ccs_pkg::LvlTwo) begin
        run_o.data[n[ccs_pkg::IdxW-1:0]] = d0_d;
        n = n + 1'b1;
      end
      if (lvl_d == ccs_pkg::LvlTwo) begin
        run_o.data[n[ccs_pkg::IdxW-1:0]] = d1_d;
        n = n + 1'b1;
      end
      lvl_d         = ccs_pkg::LvlNone;
      run_o.str_end = 1'b1;
      if (n == '0) begin
        run_o.bare = 1'b1;
        n          = ccs_pkg::CntW'(1);
      end
    end

    run_o.count = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q <= ccs_pkg::LvlNone;
    end else if (advance_i) begin
      lvl_q <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      d0_q <= d0_d;
      d1_q <= d1_d;
    end
  end

endmodule

// ===== hdl/ccs_emit.sv =====
// result buffer: holds one run and hands it out one transaction a cycle while the output is ready
// depends on ccs_pkg
`timescale 1ns / 1ps

module ccs_emit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  ccs_pkg::run_t run_i,
  output logic          free_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ccs_pkg::out_t out_data_o
);

  logic                      valid_q;
  ccs_pkg::run_t             run_q;
  logic [ccs_pkg::IdxW-1:0]  idx_q;
  logic                      last;
  logic                      fire;

  assign last   = ({1'b0, idx_q} == (run_q.count - 1'b1));
  assign fire   = valid_q && out_ready_i;
  // buffer can take a new run when empty or when its last entry leaves now
  assign free_o = !valid_q || (fire && last);

  assign out_valid_o           = valid_q;
  assign out_data_o.out_byte   = run_q.bare ? 8'h00 : run_q.data[idx_q];
  assign out_data_o.byte_valid = !run_q.bare;
  assign out_data_o.string_end = run_q.str_end && last;
  assign out_data_o.run_last   = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (fire) begin
      if (last) begin
        valid_q <= 1'b0;
        idx_q   <= '0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      run_q <= run_i;
    end
  end

  a_load_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("run loaded while buffer busy");

  a_idx_in_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ({1'b0, idx_q} < run_q.count))
    else $error("read index beyond run");

  a_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && last && !load_i) |=> !valid_q)
    else $error("buffer still valid after last transaction");

  a_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !last && !load_i) |=> (valid_q && idx_q == $past(idx_q) + 1'b1))
    else $error("read index did not step");

endmodule
